// ===== hw/rtl/dzs_pkg.sv =====
// Shared constants, payload types and register indexes for the dead-zone scaler.
package dzs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = 16;
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int RES_W       = SQ_W + 1;
    localparam int LEN_W       = SAMPLE_BITS;
    localparam int SQRT_STEPS  = SAMPLE_BITS;
    localparam int TDZ_W       = 15;
    localparam int DZ_W        = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int TNUM_W      = DZ_W + FRAC_BITS;
    localparam int NUM_W       = SQ_W + FRAC_BITS + 1;
    localparam int DEN_W       = 2 * DZ_W;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int PROD_W      = MAG_W + LEN_W;

    localparam logic [TDZ_W-1:0]  TRIG_DZ_RST  = TDZ_W'(250);
    localparam logic [DZ_W-1:0]   STICK_DZ_RST = DZ_W'(8000);
    localparam logic [DZ_W-1:0]   FULL_RST     = DZ_W'(30000);
    localparam logic [OUT_BITS-1:0] ONE_FIX    = OUT_BITS'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIG_DZ  = 2'd0,
        REG_STICK_DZ = 2'd1,
        REG_FULL     = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic              mode;
        logic              sx;
        logic              sy;
        logic              zero;
        logic              one;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [TNUM_W-1:0] tnum;
        logic [DZ_W-1:0]   tden;
    } sqrt_pay_t;

    typedef struct packed {
        logic mode;
        logic sx;
        logic sy;
        logic zero;
        logic one;
    } div_pay_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } div_lane_t;

endpackage

// ===== hw/rtl/gamepad_axis_dead_zone_scaler_core.sv =====
// Top level of the gamepad axis dead-zone scaler pipeline.
// The slave stream takes one word per sample: s_tdata holds raw_x in the low
// half and raw_y in the high half, and s_tuser selects trigger mode (0) or
// stick mode (1). The master stream returns one word per sample with out_x in
// the low half and out_y in the high half, in fixed point where 16384 is 1.0.
// The block accepts one word every clock while the output is not stalled and
// keeps many samples in flight. The edge that accepts a word loads the first of
// 37 register stages: four front stages, sixteen square-root stages, one
// scaling stage, fifteen divider stages and the output register. The square-root
// and divider chains settle one bit per stage.
// The configuration port writes the trigger dead zone (index 0), the stick
// dead zone (index 1) and full scale (index 2); other indexes are ignored.
// The user must make writes only while no sample is in flight (not enforced).
// Reset clears every valid bit and loads the default register values.
// When the receiver stalls, the whole pipeline holds its contents and s_tready
// falls, so no word is lost or repeated; it rises again as soon as the output
// word is taken.
module gamepad_axis_dead_zone_scaler_core
    import dzs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // raw_x[15:0], raw_y[31:16]
    input  logic                 s_tuser,   // mode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // out_x[15:0], out_y[31:16]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic en;

    logic [TDZ_W-1:0] trig_dz_reg;
    logic [DZ_W-1:0]  stick_dz_reg;
    logic [DZ_W-1:0]  full_reg;
    logic [SQ_W-1:0]  dz_sq_reg;

    logic                          p0_valid_reg;
    logic                          p0_mode_reg;
    logic signed [SAMPLE_BITS-1:0] p0_x_reg;
    logic signed [SAMPLE_BITS-1:0] p0_y_reg;

    logic             p1_valid_reg;
    logic             p1_mode_reg;
    logic             p1_sx_reg;
    logic             p1_sy_reg;
    logic [MAG_W-1:0] p1_mx_reg;
    logic [MAG_W-1:0] p1_my_reg;

    logic              p2_valid_reg;
    logic              p2_mode_reg;
    logic              p2_sx_reg;
    logic              p2_sy_reg;
    logic [MAG_W-1:0]  p2_mx_reg;
    logic [MAG_W-1:0]  p2_my_reg;
    logic [SQ_W-1:0]   p2_sqx_reg;
    logic [SQ_W-1:0]   p2_sqy_reg;
    logic              p2_tz_reg;
    logic              p2_tone_reg;
    logic [TNUM_W-1:0] p2_tnum_reg;
    logic [DZ_W-1:0]   p2_tden_reg;
    logic [MAG_W-1:0]  t_ex;
    logic [DZ_W-1:0]   t_span;

    logic             p3_valid_reg;
    logic [SQ_W-1:0]  p3_s_reg;
    sqrt_pay_t        p3_pay_reg;
    sqrt_pay_t        p3_pay_next;
    logic [SQ_W-1:0]  s_sum;

    logic             sq_valid [0:SQRT_STEPS];
    logic [SQ_W-1:0]  sq_rem   [0:SQRT_STEPS];
    logic [RES_W-1:0] sq_res   [0:SQRT_STEPS];
    sqrt_pay_t        sq_pay   [0:SQRT_STEPS];

    logic              ps_valid_reg;
    div_pay_t          ps_pay_reg;
    logic              ps_case_a_reg;
    logic [MAG_W-1:0]  ps_mx_reg;
    logic [MAG_W-1:0]  ps_my_reg;
    logic [LEN_W-1:0]  ps_len_reg;
    logic [PROD_W-1:0] ps_pnx_reg;
    logic [PROD_W-1:0] ps_pny_reg;
    logic [DEN_W-1:0]  ps_pd_reg;
    logic [TNUM_W-1:0] ps_tnum_reg;
    logic [DZ_W-1:0]   ps_tden_reg;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  len_excess;
    sqrt_pay_t         sq_last;

    logic      dv_valid [0:Q_W];
    div_lane_t dv_x     [0:Q_W];
    div_lane_t dv_y     [0:Q_W];
    div_pay_t  dv_pay   [0:Q_W];

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_x_reg;
    logic [OUT_BITS-1:0] out_x_next;
    logic [OUT_BITS-1:0] out_y_reg;
    logic [OUT_BITS-1:0] out_y_next;
    logic [OUT_BITS-1:0] mag_x;
    logic [OUT_BITS-1:0] mag_y;

    assign en       = m_tready || !out_valid_reg;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_dz_reg  <= TRIG_DZ_RST;
            stick_dz_reg <= STICK_DZ_RST;
            full_reg     <= FULL_RST;
            dz_sq_reg    <= SQ_W'(STICK_DZ_RST) * SQ_W'(STICK_DZ_RST);
        end
        else
        begin
            dz_sq_reg <= SQ_W'(stick_dz_reg) * SQ_W'(stick_dz_reg);
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_TRIG_DZ:  trig_dz_reg  <= cfg_data[TDZ_W-1:0];
                    REG_STICK_DZ: stick_dz_reg <= cfg_data[DZ_W-1:0];
                    REG_FULL:     full_reg     <= cfg_data[DZ_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            ps_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_valid_reg  <= s_tvalid;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            ps_valid_reg  <= sq_valid[SQRT_STEPS];
            out_valid_reg <= dv_valid[Q_W];
        end
    end

    always_comb
    begin
        t_ex   = p1_mx_reg - MAG_W'(trig_dz_reg);
        t_span = full_reg - DZ_W'(trig_dz_reg);
        s_sum  = p2_sqx_reg + p2_sqy_reg;
        p3_pay_next.mode = p2_mode_reg;
        p3_pay_next.sx   = p2_sx_reg;
        p3_pay_next.sy   = p2_sy_reg;
        p3_pay_next.mx   = p2_mx_reg;
        p3_pay_next.my   = p2_my_reg;
        p3_pay_next.tnum = p2_tnum_reg;
        p3_pay_next.tden = p2_tden_reg;
        if (p2_mode_reg)
        begin
            p3_pay_next.zero = (s_sum < dz_sq_reg) || (s_sum == '0);
            p3_pay_next.one  = 1'b0;
        end
        else
        begin
            p3_pay_next.zero = p2_tz_reg;
            p3_pay_next.one  = p2_tone_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_mode_reg <= s_tuser;
            p0_x_reg    <= s_tdata[SAMPLE_BITS-1:0];
            p0_y_reg    <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

            p1_mode_reg <= p0_mode_reg;
            p1_sx_reg   <= p0_x_reg[SAMPLE_BITS-1];
            p1_sy_reg   <= p0_y_reg[SAMPLE_BITS-1];
            p1_mx_reg   <= p0_x_reg[SAMPLE_BITS-1]
                           ? MAG_W'(-$signed({p0_x_reg[SAMPLE_BITS-1], p0_x_reg}))
                           : MAG_W'(p0_x_reg);
            p1_my_reg   <= p0_y_reg[SAMPLE_BITS-1]
                           ? MAG_W'(-$signed({p0_y_reg[SAMPLE_BITS-1], p0_y_reg}))
                           : MAG_W'(p0_y_reg);

            p2_mode_reg <= p1_mode_reg;
            p2_sx_reg   <= p1_sx_reg;
            p2_sy_reg   <= p1_sy_reg;
            p2_mx_reg   <= p1_mx_reg;
            p2_my_reg   <= p1_my_reg;
            p2_sqx_reg  <= SQ_W'(p1_mx_reg) * SQ_W'(p1_mx_reg);
            p2_sqy_reg  <= SQ_W'(p1_my_reg) * SQ_W'(p1_my_reg);
            p2_tz_reg   <= p1_mx_reg <= MAG_W'(trig_dz_reg);
            p2_tone_reg <= (full_reg <= DZ_W'(trig_dz_reg)) || (t_ex >= MAG_W'(t_span));
            p2_tnum_reg <= TNUM_W'(t_ex[DZ_W-1:0]) << FRAC_BITS;
            p2_tden_reg <= t_span;

            p3_s_reg    <= s_sum;
            p3_pay_reg  <= p3_pay_next;
        end
    end

    assign sq_valid[0] = p3_valid_reg;
    assign sq_rem[0]   = p3_s_reg;
    assign sq_res[0]   = '0;
    assign sq_pay[0]   = p3_pay_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        dzs_sqrt_stage #(
            .STEP (SQRT_STEPS - 1 - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[k]),
            .in_rem    (sq_rem[k]),
            .in_res    (sq_res[k]),
            .in_pay    (sq_pay[k]),
            .out_valid (sq_valid[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_res   (sq_res[k+1]),
            .out_pay   (sq_pay[k+1])
        );
    end

    always_comb
    begin
        sq_last    = sq_pay[SQRT_STEPS];
        len        = sq_res[SQRT_STEPS][LEN_W-1:0];
        len_excess = len - stick_dz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_pay_reg.mode <= sq_last.mode;
            ps_pay_reg.sx   <= sq_last.sx;
            ps_pay_reg.sy   <= sq_last.sy;
            ps_pay_reg.zero <= sq_last.zero;
            ps_pay_reg.one  <= sq_last.one;
            ps_case_a_reg   <= (full_reg <= stick_dz_reg) || (len >= full_reg);
            ps_mx_reg       <= sq_last.mx;
            ps_my_reg       <= sq_last.my;
            ps_len_reg      <= len;
            ps_pnx_reg      <= PROD_W'(sq_last.mx) * PROD_W'(len_excess);
            ps_pny_reg      <= PROD_W'(sq_last.my) * PROD_W'(len_excess);
            ps_pd_reg       <= DEN_W'(full_reg - stick_dz_reg) * DEN_W'(len);
            ps_tnum_reg     <= sq_last.tnum;
            ps_tden_reg     <= sq_last.tden;
        end
    end

    always_comb
    begin
        dv_valid[0] = ps_valid_reg;
        dv_pay[0]   = ps_pay_reg;
        dv_x[0].q   = '0;
        dv_y[0].q   = '0;
        if (ps_case_a_reg)
        begin
            dv_y[0].rem = NUM_W'(ps_my_reg) << FRAC_BITS;
            dv_y[0].den = DEN_W'(ps_len_reg);
        end
        else
        begin
            dv_y[0].rem = NUM_W'(ps_pny_reg) << FRAC_BITS;
            dv_y[0].den = ps_pd_reg;
        end
        if (!ps_pay_reg.mode)
        begin
            dv_x[0].rem = NUM_W'(ps_tnum_reg);
            dv_x[0].den = DEN_W'(ps_tden_reg);
        end
        else if (ps_case_a_reg)
        begin
            dv_x[0].rem = NUM_W'(ps_mx_reg) << FRAC_BITS;
            dv_x[0].den = DEN_W'(ps_len_reg);
        end
        else
        begin
            dv_x[0].rem = NUM_W'(ps_pnx_reg) << FRAC_BITS;
            dv_x[0].den = ps_pd_reg;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        dzs_div_stage #(
            .STEP (Q_W - 1 - k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[k]),
            .in_x      (dv_x[k]),
            .in_y      (dv_y[k]),
            .in_pay    (dv_pay[k]),
            .out_valid (dv_valid[k+1]),
            .out_x     (dv_x[k+1]),
            .out_y     (dv_y[k+1]),
            .out_pay   (dv_pay[k+1])
        );
    end

    always_comb
    begin
        if (dv_pay[Q_W].zero)
        begin
            mag_x = '0;
        end
        else if (dv_pay[Q_W].one)
        begin
            mag_x = ONE_FIX;
        end
        else
        begin
            mag_x = OUT_BITS'(dv_x[Q_W].q);
        end
        if (!dv_pay[Q_W].mode || dv_pay[Q_W].zero)
        begin
            mag_y = '0;
        end
        else
        begin
            mag_y = OUT_BITS'(dv_y[Q_W].q);
        end
        out_x_next = dv_pay[Q_W].sx ? (~mag_x + OUT_BITS'(1)) : mag_x;
        out_y_next = dv_pay[Q_W].sy ? (~mag_y + OUT_BITS'(1)) : mag_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    // The pipeline advances exactly when the output word is free or being taken.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (m_tready || !m_tvalid))
        else $error("s_tready does not follow the output stall");

    a_out_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384))
        else $error("out_x beyond full deflection");

    a_out_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384))
        else $error("out_y beyond full deflection");

    a_front_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s_tvalid) |=> p0_valid_reg)
        else $error("accepted word missing from the first stage");

endmodule

// ===== hw/rtl/dzs_sqrt_stage.sv =====
// One restoring square-root step: settles one result bit per pipeline stage.
module dzs_sqrt_stage
    import dzs_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SQ_W-1:0]  in_rem,
    input  logic [RES_W-1:0] in_res,
    input  sqrt_pay_t        in_pay,
    output logic             out_valid,
    output logic [SQ_W-1:0]  out_rem,
    output logic [RES_W-1:0] out_res,
    output sqrt_pay_t        out_pay
);

    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * STEP);

    logic             valid_reg;
    logic [SQ_W-1:0]  rem_reg;
    logic [SQ_W-1:0]  rem_next;
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;
    sqrt_pay_t        pay_reg;
    logic [RES_W-1:0] trial;
    logic             take;

    always_comb
    begin
        trial = in_res + BIT;
        take  = {1'b0, in_rem} >= trial;
        if (take)
        begin
            rem_next = in_rem - trial[SQ_W-1:0];
            res_next = (in_res >> 1) + BIT;
        end
        else
        begin
            rem_next = in_rem;
            res_next = in_res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_res   = res_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== hw/rtl/dzs_div_stage.sv =====
// One restoring division step for both axis lanes: one quotient bit per stage.
module dzs_div_stage
    import dzs_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  div_lane_t in_x,
    input  div_lane_t in_y,
    input  div_pay_t  in_pay,
    output logic      out_valid,
    output div_lane_t out_x,
    output div_lane_t out_y,
    output div_pay_t  out_pay
);

    logic      valid_reg;
    div_lane_t x_reg;
    div_lane_t x_next;
    div_lane_t y_reg;
    div_lane_t y_next;
    div_pay_t  pay_reg;

    function automatic div_lane_t div_step(input div_lane_t l);
        logic [NUM_W-1:0] shifted;
        div_lane_t        r;
        shifted = NUM_W'(l.den) << STEP;
        r = l;
        if (l.rem >= shifted)
        begin
            r.rem = l.rem - shifted;
            r.q   = l.q | (Q_W'(1) << STEP);
        end
        return r;
    endfunction

    always_comb
    begin
        x_next = div_step(in_x);
        y_next = div_step(in_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== dv/gamepad_axis_dead_zone_scaler_core_tb.sv =====
// Self-checking testbench for the gamepad axis dead-zone scaler with random and directed words.
module gamepad_axis_dead_zone_scaler_core_tb;
    import dzs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 37;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] out_y;
        logic [15:0] out_x;
    } scaled_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    longint unsigned trig_dz;
    longint unsigned stick_dz;
    longint unsigned full;

    scaled_t expected_words[$];
    int errors;
    int sent_trigger;
    int sent_stick;
    int checked;
    int cycles;
    int hold_cycles;
    bit quiet_sender;
    bit quiet_receiver;

    gamepad_axis_dead_zone_scaler_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] apply_sign(longint unsigned m, bit neg);
        logic [15:0] v;
        v = m[15:0];
        return neg ? -v : v;
    endfunction

    function automatic longint unsigned trigger_level(longint unsigned a);
        longint unsigned span;
        longint unsigned ex;
        longint unsigned v;
        if (a <= trig_dz)
            return 0;
        if (full <= trig_dz)
            return 64'd1 << FRAC_BITS;
        span = full - trig_dz;
        ex = a - trig_dz;
        if (ex >= span)
            return 64'd1 << FRAC_BITS;
        v = (ex << FRAC_BITS) / span;
        return v > (64'd1 << FRAC_BITS) ? (64'd1 << FRAC_BITS) : v;
    endfunction

    function automatic longint unsigned stick_level(longint unsigned m, longint unsigned len);
        if (full <= stick_dz || len >= full)
            return (m << FRAC_BITS) / len;
        return ((m * (len - stick_dz)) << FRAC_BITS) / ((full - stick_dz) * len);
    endfunction

    function automatic scaled_t condition(bit mode, logic signed [15:0] x, logic signed [15:0] y);
        scaled_t r;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned s;
        longint unsigned len;
        mx = x < 0 ? -longint'(x) : longint'(x);
        my = y < 0 ? -longint'(y) : longint'(y);
        r = '0;
        if (!mode)
            r.out_x = apply_sign(trigger_level(mx), x < 0);
        else
        begin
            s = mx * mx + my * my;
            if (!(s < stick_dz * stick_dz || s == 0))
            begin
                len = root_floor(s);
                r.out_x = apply_sign(stick_level(mx, len), x < 0);
                r.out_y = apply_sign(stick_level(my, len), y < 0);
            end
        end
        return r;
    endfunction

    task automatic send_sample(bit mode, logic [15:0] x, logic [15:0] y);
        if (!quiet_sender)
        begin
            while ($urandom_range(99) < 17)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(condition(mode, x, y));
        if (mode)
            sent_stick++;
        else
            sent_trigger++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TRIG_DZ:  trig_dz = value & 16'h7FFF;
            REG_STICK_DZ: stick_dz = value;
            REG_FULL:     full = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_limits(logic [15:0] tdz, logic [15:0] sdz, logic [15:0] fs);
        drain();
        write_reg(REG_TRIG_DZ, tdz);
        write_reg(REG_STICK_DZ, sdz);
        write_reg(REG_FULL, fs);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed_defaults();
        send_sample(1'b0, 16'h0000, 16'h0000);
        send_sample(1'b0, 16'd250, 16'hFFFF);
        send_sample(1'b0, 16'd251, 16'h0000);
        send_sample(1'b0, -16'sd251, 16'h0000);
        send_sample(1'b0, 16'h7FFF, 16'h1234);
        send_sample(1'b0, 16'h8000, 16'h8000);
        send_sample(1'b0, 16'd15000, 16'h0000);
        send_sample(1'b1, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'd8000, 16'h0000);
        send_sample(1'b1, 16'd7999, 16'h0000);
        send_sample(1'b1, 16'd5657, 16'd5657);
        send_sample(1'b1, 16'h8000, 16'h8000);
        send_sample(1'b1, 16'h7FFF, 16'h8000);
        send_sample(1'b1, -16'sd12000, 16'd9000);
        send_sample(1'b1, 16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_degenerate_limits();
        set_limits(16'h7FFF, 16'd0, 16'd1);
        send_sample(1'b0, 16'h7FFF, 16'h0000);
        send_sample(1'b0, 16'h8000, 16'h0000);
        send_sample(1'b1, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'h0001, 16'hFFFF);
        send_sample(1'b1, 16'h8000, 16'h7FFF);
        set_limits(16'd0, 16'd46341, 16'd46341);
        send_sample(1'b0, 16'h0001, 16'h0000);
        send_sample(1'b0, 16'hFFFF, 16'h0000);
        send_sample(1'b1, 16'h8000, 16'h8000);
        send_sample(1'b1, 16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            set_limits(16'($urandom_range(32767)), 16'($urandom_range(46341)),
                       16'($urandom_range(46341, 1)));
            quiet_sender = (phase == 2);
            quiet_receiver = (phase == 2);
            for (int i = 0; i < 130; i++)
                send_sample(1'($urandom), random_sample(), random_sample());
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    task automatic test_back_pressure();
        set_limits(16'd250, 16'd8000, 16'd30000);
        quiet_sender = 1'b1;
        hold_cycles = 200;
        for (int i = 0; i < 120; i++)
            send_sample(1'($urandom), random_sample(), random_sample());
        quiet_sender = 1'b0;
        drain();
        for (int i = 0; i < 100; i++)
            send_sample(1'($urandom), random_sample(), random_sample());
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet_receiver ? 1'b1 : ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        scaled_t got;
        scaled_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_x=%0d out_y=%0d",
                       $signed(got.out_x), $signed(got.out_y));
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.out_x !== want.out_x)
                begin
                    $error("out_x expected %0d actual %0d",
                           $signed(want.out_x), $signed(got.out_x));
                    errors++;
                end
                if (got.out_y !== want.out_y)
                begin
                    $error("out_y expected %0d actual %0d",
                           $signed(want.out_y), $signed(got.out_y));
                    errors++;
                end
                checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("gamepad_axis_dead_zone_scaler_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        trig_dz = 250;
        stick_dz = 8000;
        full = 30000;
        errors = 0;
        checked = 0;
        sent_trigger = 0;
        sent_stick = 0;
        cycles = 0;
        hold_cycles = 0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TRIG_DZ;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_defaults();
        test_degenerate_limits();
        test_random_settings();
        test_back_pressure();
        drain();
        $display("Checked %0d words: %0d trigger and %0d stick samples over ten configurations,",
                 checked, sent_trigger, sent_stick);
        $display("including extreme limits, random idling and a long output stall.");
        if (errors == 0 && expected_words.size() == 0)
            $display("gamepad_axis_dead_zone_scaler_core_tb: PASS");
        else
            $display("gamepad_axis_dead_zone_scaler_core_tb: FAIL");
        $finish;
    end
endmodule
